// ----- rtl/lbp_pkg.sv -----
// Package for the two-level local branch predictor.
// Holds default sizes, the sequencer state type and the counter update.
// No dependencies.
package lbp_pkg;

  // Default table sizes
  localparam int unsigned HistIdxBitsDef = 10;
  localparam int unsigned PatternBitsDef = 10;

  // Request field widths
  localparam int unsigned AddrW = 64;

  // Two-bit counter constants
  localparam logic [1:0] CtrReset = 2'd1;
  localparam logic [1:0] CtrMax   = 2'd3;
  localparam logic [1:0] CtrMin   = 2'd0;

  // Request type codes
  localparam logic ReqPredict = 1'b0;
  localparam logic ReqUpdate  = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_PAT
  } lbp_state_e;

  // Saturating step toward the outcome
  function automatic logic [1:0] ctr_step(input logic [1:0] ctr, input logic taken);
    logic [1:0] res;
    res = ctr;
    if (taken) begin
      if (ctr != CtrMax) res = ctr + 2'd1;
    end else begin
      if (ctr != CtrMin) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

// ----- rtl/lbp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lbp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [Width-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [Width-1:0]  rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/two_level_local_branch_predictor_top.sv -----
// Top level of the two-level local branch predictor.
// Depends on lbp_pkg and lbp_ram.
//
// Usage:
// - Input channel (in_valid_i / in_ready_o) carries one request: req_type_i
//   (0 predict, 1 update), branch_addr_i and outcome_taken_i.
// - Output channel (out_valid_o / out_ready_i) returns one predict_taken_o
//   per request, in request order. Updates return the pre-training value.
// - On acceptance the history RAM is read, in ST_HIST the pattern RAM,
//   and in ST_PAT the result is registered and, for an update, both tables
//   are written back. ST_PAT waits while the output register is full. The
//   next request is accepted only once the sequencer is back in ST_IDLE, so
//   the block never takes a new request before the previous one is done.
// - Only one request is in flight, so write-back always lands before the
//   next read and no forwarding is needed.
// - After reset a clearing pass writes every table entry, one per cycle.
//   in_ready_o stays low during the pass.
// - If the receiver stalls with a result pending, the next request is still
//   accepted and read; it waits in the last step until the output register
//   frees up.
module two_level_local_branch_predictor_top
  import lbp_pkg::*;
#(
  parameter int unsigned HistIdxBits = HistIdxBitsDef,
  parameter int unsigned PatternBits = PatternBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             req_type_i,
  input  logic [AddrW-1:0] branch_addr_i,
  input  logic             outcome_taken_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             predict_taken_o
);

  localparam int unsigned HtDepth = 1 << HistIdxBits;
  localparam int unsigned PtDepth = 1 << PatternBits;
  localparam int unsigned MaxBits = (HistIdxBits > PatternBits) ? HistIdxBits : PatternBits;
  localparam int unsigned ClrW    = MaxBits + 1;
  localparam logic [ClrW-1:0] HtDepthC = ClrW'(HtDepth);
  localparam logic [ClrW-1:0] PtDepthC = ClrW'(PtDepth);
  localparam logic [ClrW-1:0] ClrLast  = ClrW'((1 << MaxBits) - 1);

  lbp_state_e state_q, state_d;

  logic [ClrW-1:0]        clr_cnt_q, clr_cnt_d;
  logic                   req_q;
  logic                   taken_q;
  logic [HistIdxBits-1:0] hidx_q;
  logic [PatternBits-1:0] pidx_q;
  logic                   out_valid_q, out_valid_d;
  logic                   pred_q;

  logic                   accept;
  logic                   pat_done;

  logic                   ht_we, ht_re;
  logic [HistIdxBits-1:0] ht_waddr;
  logic [PatternBits-1:0] ht_wdata, ht_rdata;
  logic                   pt_we, pt_re;
  logic [PatternBits-1:0] pt_waddr;
  logic [1:0]             pt_wdata, pt_rdata;

  assign accept   = in_valid_i && in_ready_o;
  assign pat_done = (state_q == ST_PAT) && (!out_valid_q || out_ready_i);

  // History table
  lbp_ram #(.Width(PatternBits), .Depth(HtDepth)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ht_we),
    .waddr_i (ht_waddr),
    .wdata_i (ht_wdata),
    .re_i    (ht_re),
    .raddr_i (branch_addr_i[HistIdxBits+1:2]),
    .rdata_o (ht_rdata)
  );

  // Pattern table
  lbp_ram #(.Width(2), .Depth(PtDepth)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .re_i    (pt_re),
    .raddr_i (ht_rdata),
    .rdata_o (pt_rdata)
  );

  // Next state
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + ClrW'(1);
        if (clr_cnt_q == ClrLast) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_HIST;
      end
      ST_HIST: begin
        state_d = ST_PAT;
      end
      ST_PAT: begin
        if (pat_done) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: input ready and RAM controls
  always_comb begin
    in_ready_o = 1'b0;
    ht_re      = 1'b0;
    pt_re      = 1'b0;
    ht_we      = 1'b0;
    pt_we      = 1'b0;
    ht_waddr   = hidx_q;
    ht_wdata   = PatternBits'({pidx_q, taken_q});
    pt_waddr   = pidx_q;
    pt_wdata   = ctr_step(pt_rdata, taken_q);
    case (state_q)
      ST_CLEAR: begin
        ht_we    = (clr_cnt_q < HtDepthC);
        pt_we    = (clr_cnt_q < PtDepthC);
        ht_waddr = clr_cnt_q[HistIdxBits-1:0];
        ht_wdata = '0;
        pt_waddr = clr_cnt_q[PatternBits-1:0];
        pt_wdata = CtrReset;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ht_re      = in_valid_i;
      end
      ST_HIST: begin
        pt_re = 1'b1;
      end
      ST_PAT: begin
        ht_we = pat_done && (req_q == ReqUpdate);
        pt_we = pat_done && (req_q == ReqUpdate);
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (pat_done)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      taken_q <= outcome_taken_i;
      hidx_q  <= branch_addr_i[HistIdxBits+1:2];
    end
    if (state_q == ST_HIST) pidx_q <= ht_rdata;
    if (pat_done) pred_q <= pt_rdata[1];
  end

  assign out_valid_o     = out_valid_q;
  assign predict_taken_o = pred_q;

  // Checks
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("request accepted during clearing pass");

  a_hist_to_pat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HIST) |=> (state_q == ST_PAT))
    else $error("history read not followed by pattern step");

  a_accept_to_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_HIST))
    else $error("accepted request did not start history read");

  a_pat_write_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_we |-> ((state_q == ST_PAT) || (state_q == ST_CLEAR)))
    else $error("pattern write outside write-back or clear");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_PAT))
    else $error("result raised outside pattern step");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for two_level_local_branch_predictor_top: predicts each transaction
// with a local-history table model and checks every returned prediction in order.
// Depends on lbp_pkg and the two_level_local_branch_predictor_top RTL.
module tb;
  import lbp_pkg::*;

  localparam int unsigned HistEntries = 1 << HistIdxBitsDef;
  localparam int unsigned PatEntries  = 1 << PatternBitsDef;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LoopCount   = 16;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             req_type_i = ReqPredict;
  logic [AddrW-1:0] branch_addr_i = '0;
  logic             outcome_taken_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             predict_taken_o;

  // Shadow tables and outstanding predictions
  logic [PatternBitsDef-1:0] local_hist_tbl [HistEntries];
  logic [1:0]                pattern_ctr_tbl [PatEntries];
  logic                      pending_predictions [$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned hold_cycles_req = 0;
  bit          tx_gap_on = 1'b1;
  bit          rx_stall_on = 1'b1;

  // Loop-like branches reused by the random phase
  logic [AddrW-1:0] loop_addr [LoopCount];
  logic [7:0]       loop_pattern [LoopCount];
  int unsigned      loop_period [LoopCount];
  int unsigned      loop_phase [LoopCount];

  two_level_local_branch_predictor_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .branch_addr_i  (branch_addr_i),
    .outcome_taken_i(outcome_taken_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .predict_taken_o(predict_taken_o)
  );

  always #6 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("** two_level_local_branch_predictor_top: FAILED **");
      $finish;
    end
  end

  // Mostly short idle stretches, a few long ones
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned sender_gap();
    if (!tx_gap_on || $urandom_range(0, 99) < 55) return 0;
    return idle_len();
  endfunction

  // Lookup of the pre-training prediction, then training on update transactions
  function automatic logic lookup_and_train(input logic req, input logic [AddrW-1:0] addr,
                                            input logic taken);
    logic [HistIdxBitsDef-1:0] hslot;
    logic [PatternBitsDef-1:0] pslot;
    logic [1:0]                ctr;
    logic                      guess;
    hslot = addr[HistIdxBitsDef+1:2];
    pslot = local_hist_tbl[hslot];
    ctr   = pattern_ctr_tbl[pslot];
    guess = ctr[1];
    if (req == ReqUpdate) begin
      if (taken) begin
        if (ctr != CtrMax) ctr = ctr + 2'd1;
      end else begin
        if (ctr != CtrMin) ctr = ctr - 2'd1;
      end
      pattern_ctr_tbl[pslot] = ctr;
      local_hist_tbl[hslot]  = {pslot[PatternBitsDef-2:0], taken};
    end
    return guess;
  endfunction

  // Offer one transaction, optionally after an idle gap; returns at acceptance
  task automatic send_request(input logic req, input logic [AddrW-1:0] addr,
                              input logic taken);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    branch_addr_i   <= addr;
    outcome_taken_i <= taken;
    do @(posedge clk_i); while (!in_ready_o);
    pending_predictions.push_back(lookup_and_train(req, addr, taken));
  endtask

  // Result check and receiver stalls
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (pending_predictions.size() == 0) begin
        $error("predict_taken: result with nothing pending, actual %0b", predict_taken_o);
        fail_count++;
      end else begin
        logic exp_taken;
        exp_taken = pending_predictions.pop_front();
        if (predict_taken_o !== exp_taken) begin
          $error("predict_taken: expected %0b, actual %0b", exp_taken, predict_taken_o);
          fail_count++;
        end
      end
    end
    if (hold_cycles_req != 0) begin
      stall_left      = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = idle_len() - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Fresh tables predict not-taken everywhere, including the address extremes
  task automatic test_reset_state();
    send_request(ReqPredict, '0, 1'b0);
    send_request(ReqPredict, '1, 1'b1);
    send_request(ReqPredict, 64'h8000_0000_0000_0ffc, 1'b0);
  endtask

  // Low two bits and bits above the index do not select the history entry
  task automatic test_aliasing();
    send_request(ReqUpdate, 64'h0000_0000_0000_0040, 1'b1);
    send_request(ReqPredict, 64'h0000_0000_0000_0043, 1'b0);
    send_request(ReqUpdate, 64'hffff_0000_0000_1041, 1'b1);
    send_request(ReqPredict, 64'h1234_5678_0000_0042, 1'b0);
  endtask

  // Drive a counter into both bounds; predict-only ignores the outcome
  task automatic test_counter_bounds();
    for (int i = 0; i < 13; i++) send_request(ReqUpdate, 64'h0000_0000_0000_0200, 1'b1);
    send_request(ReqPredict, 64'h0000_0000_0000_0200, 1'b1);
    send_request(ReqPredict, 64'h0000_0000_0000_0200, 1'b0);
    for (int i = 0; i < 4; i++) send_request(ReqUpdate, 64'h0000_0000_0000_0300, 1'b0);
    send_request(ReqPredict, 64'h0000_0000_0000_0300, 1'b1);
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    bit saved_gap;
    saved_gap       = tx_gap_on;
    tx_gap_on       = 1'b0;
    hold_cycles_req = 300;
    for (int i = 0; i < 30; i++)
      send_request(logic'($urandom_range(0, 1)), {$urandom, $urandom},
                   logic'($urandom_range(0, 1)));
    tx_gap_on = saved_gap;
  endtask

  // Mostly periodic loop branches, plus random and edge-index noise
  task automatic test_random_traffic();
    int unsigned      r;
    int unsigned      k;
    logic [AddrW-1:0] addr;
    logic             taken;
    for (int i = 0; i < LoopCount; i++) begin
      if (i >= 12) loop_addr[i] = loop_addr[i-12] ^ (64'h1 << $urandom_range(12, 63))
                                  ^ 64'($urandom_range(0, 3));
      else loop_addr[i] = {$urandom, $urandom};
      loop_pattern[i] = 8'($urandom);
      loop_period[i]  = $urandom_range(1, 8);
      loop_phase[i]   = 0;
    end
    for (int chunk = 0; chunk < 10; chunk++) begin
      tx_gap_on   = (chunk != 0) && ($urandom_range(0, 2) != 0);
      rx_stall_on = (chunk != 0) && ($urandom_range(0, 2) != 0);
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          k     = $urandom_range(0, LoopCount - 1);
          taken = loop_pattern[k][loop_phase[k]];
          loop_phase[k] = (loop_phase[k] + 1) % loop_period[k];
          if ($urandom_range(0, 99) < 85) send_request(ReqUpdate, loop_addr[k], taken);
          else send_request(ReqPredict, loop_addr[k], logic'($urandom_range(0, 1)));
        end else if (r < 90) begin
          send_request(logic'($urandom_range(0, 1)), {$urandom, $urandom},
                       logic'($urandom_range(0, 1)));
        end else begin
          addr = {$urandom, $urandom};
          addr[HistIdxBitsDef+1:2] = $urandom_range(0, 1) ? '1 : '0;
          send_request(logic'($urandom_range(0, 1)), addr, logic'($urandom_range(0, 1)));
        end
      end
    end
    tx_gap_on   = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  initial begin
    foreach (local_hist_tbl[i]) local_hist_tbl[i] = '0;
    foreach (pattern_ctr_tbl[i]) pattern_ctr_tbl[i] = CtrReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_aliasing();
    test_counter_bounds();
    test_backpressure();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (pending_predictions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** two_level_local_branch_predictor_top: PASSED **");
    end else begin
      $display("** two_level_local_branch_predictor_top: FAILED **");
    end
    $finish;
  end

endmodule
